FILE: rtl/smcm_pkg.sv
// Shared types and constants for the stereo matrix correlation meter.
// Used by every module of the block; depends on nothing.

package smcm_pkg;

   localparam int SAMPLE_BITS_DEF = 24;
   localparam int SUM_W           = 60;
   localparam int CORR_W          = 16;
   localparam int QUOT_W          = 17;
   localparam int DIV_STEPS       = 16;
   localparam int CSR_ADDR_W      = 4;
   localparam int CSR_DATA_W      = 32;

   // 0.95 and 0.05 in Q15; they add up to exactly one.
   localparam logic signed [15:0] KEEP_Q15   = 16'sd31130;
   localparam logic signed [15:0] NEW_Q15    = 16'sd1638;
   localparam logic signed [32:0] ROUND_Q15  = 33'sd16384;

   typedef enum logic [2:0] {
      MODE_PASS       = 3'd0,
      MODE_MID        = 3'd1,
      MODE_SIDE       = 3'd2,
      MODE_INVERT     = 3'd3,
      MODE_SWAP       = 3'd4,
      MODE_SIDE_MONO  = 3'd5,
      MODE_LEFT_MONO  = 3'd6,
      MODE_RIGHT_MONO = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      REG_MODE   = 2'd0,
      REG_BYPASS = 2'd1,
      REG_RINV   = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACCUM,
      ST_PREP,
      ST_DIV,
      ST_SMOOTH_A,
      ST_SMOOTH_B,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } mac_ctl_type;

endpackage

FILE: rtl/stereo_matrix_correlation_meter_top.sv
// Top level of the stereo monitor matrix and phase correlation meter.
// Depends on smcm_pkg and smcm_mac.
//
// Usage: each word on the req_ channel is one stereo sample pair; req_tlast marks the
// last pair of a measurement block. The pair passes the monitor matrix (unless bypassed)
// and the optional right-channel inversion, and comes back on the rsp_ channel together
// with the smoothed correlation in Q1.15, which changes only on block-end words.
// The matrix settings are written through the csr_ port; the user must write them only
// while the block is idle, which the block itself does not enforce. One pair is
// processed at a time: an accepted word passes the bit-serial multiplier that forms the
// products and the accumulation of both sums. A block-end word then passes a set-up
// state, the restoring divider that forms 2P/S and the smoothing states SMOOTH_A and
// SMOOTH_B; a silent block or a ratio at full scale skips the divider. The result then
// moves into the output register, and only after that is a new pair taken, so the
// block never takes a new pair before it is done with the last.
// If the receiver stalls, the result is held in the output register and the next
// pair is processed; it then waits until the output register is free.
// Reset clears the matrix settings, both sums, the smoothed correlation and the
// output valid flag.

module stereo_matrix_correlation_meter_top #(
   parameter  int SAMPLE_BITS = smcm_pkg::SAMPLE_BITS_DEF,
   localparam int IN_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
   localparam int OUT_W = ((2 * SAMPLE_BITS + smcm_pkg::CORR_W + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [IN_W-1:0]                   req_tdata,   // left_in, right_in
   input  logic                              req_tlast,   // block_end
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [OUT_W-1:0]                  rsp_tdata,   // left_out, right_out, correlation
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [smcm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [smcm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [smcm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int SB     = SAMPLE_BITS;
   localparam int SUM_W  = smcm_pkg::SUM_W;
   localparam int PROD_W = 2 * SB;
   localparam int SQ_W   = PROD_W + 1;
   localparam int ACC_W  = (SQ_W + 1 > SUM_W + 1) ? SQ_W + 1 : SUM_W + 1;
   localparam int CNT_W  = $clog2(SB);
   localparam int Q_W    = smcm_pkg::QUOT_W;

   localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB - 1){1'b0}}};
   localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] PSUM_MAX = {{(ACC_W - SUM_W + 1){1'b0}},
                                                   {(SUM_W - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] PSUM_MIN = {{(ACC_W - SUM_W + 1){1'b1}},
                                                   {(SUM_W - 1){1'b0}}};
   localparam logic [ACC_W-1:0] SSUM_MAX = {{(ACC_W - SUM_W){1'b0}}, {SUM_W{1'b1}}};
   localparam logic [63:0] SILENCE_64 = (64'd1 << (2 * (SAMPLE_BITS - 1))) / 64'd100000;
   localparam logic [SUM_W-1:0] SILENCE = SILENCE_64[SUM_W-1:0];
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(SB - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(smcm_pkg::DIV_STEPS - 1);
   localparam logic [Q_W-1:0] Q_FULL = {1'b1, {(Q_W - 1){1'b0}}};
   localparam logic [Q_W-1:0] Q_NEG_LIM = Q_W'(32768);
   localparam logic [Q_W-1:0] Q_POS_LIM = Q_W'(32767);

   // Configuration registers
   smcm_pkg::mode_type mode_ff, mode_in;
   logic               bypass_ff, bypass_in;
   logic               rinv_ff, rinv_in;
   logic               csr_write;
   smcm_pkg::reg_index_type csr_index;

   // Control
   smcm_pkg::state_type   state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   smcm_pkg::mac_ctl_type mac_ctl;
   logic                  accept, load_out;

   // Sample path
   logic signed [SB-1:0] l_raw, r_raw, lo_mx, ro_mx, ro_fin;
   logic signed [SB:0]   half_sum, half_diff;
   logic signed [SB-1:0] lo_ff, ro_ff;
   logic                 neg_ff, last_ff;
   logic [PROD_W-1:0]    prod_lr, prod_ll, prod_rr;

   // Sums and divider
   logic signed [SUM_W-1:0] psum_ff, psum_in;
   logic [SUM_W-1:0]        ssum_ff, ssum_in;
   logic signed [PROD_W-1:0] prod_signed;
   logic signed [ACC_W-1:0]  psum_acc;
   logic [ACC_W-1:0]         ssum_acc;
   logic [SQ_W-1:0]          sq_new;
   logic [SUM_W-1:0]         mag_p;
   logic [SUM_W:0]           rem_ff, rem_in, rem_shift;
   logic [Q_W-1:0]           q_ff, q_in;
   logic                     zero_ff, zero_in;
   logic                     div_skip;

   // Smoothing
   logic signed [15:0] corr_ff, corr_in, fresh, fresh_ff;
   logic signed [31:0] keep_ff;
   logic signed [31:0] new_part;
   logic signed [32:0] smooth_acc;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]   rsp_data_ff, rsp_data_in;

   function automatic logic signed [SB-1:0] neg_sat(input logic signed [SB-1:0] x);
      return (x == SMIN) ? SMAX : -x;
   endfunction

   function automatic logic [SB-1:0] mag_of(input logic signed [SB-1:0] x);
      return x[SB-1] ? (~x + 1'b1) : x;
   endfunction

   // ---------------------------------------------------------------- CSR port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = smcm_pkg::reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      mode_in   = mode_ff;
      bypass_in = bypass_ff;
      rinv_in   = rinv_ff;
      if (csr_write && csr_paddr[1:0] == 2'b00) begin
         case (csr_index)
            smcm_pkg::REG_MODE:   mode_in   = smcm_pkg::mode_type'(csr_pwdata[2:0]);
            smcm_pkg::REG_BYPASS: bypass_in = csr_pwdata[0];
            smcm_pkg::REG_RINV:   rinv_in   = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         smcm_pkg::REG_MODE:   csr_prdata = smcm_pkg::CSR_DATA_W'(mode_ff);
         smcm_pkg::REG_BYPASS: csr_prdata = smcm_pkg::CSR_DATA_W'(bypass_ff);
         smcm_pkg::REG_RINV:   csr_prdata = smcm_pkg::CSR_DATA_W'(rinv_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- matrix
   assign l_raw     = req_tdata[SB-1:0];
   assign r_raw     = req_tdata[2*SB-1:SB];
   // An arithmetic shift of the widened sum halves it rounding toward minus infinity.
   assign half_sum  = ({l_raw[SB-1], l_raw} + {r_raw[SB-1], r_raw}) >>> 1;
   assign half_diff = ({l_raw[SB-1], l_raw} - {r_raw[SB-1], r_raw}) >>> 1;

   always_comb begin
      lo_mx = l_raw;
      ro_mx = r_raw;
      if (!bypass_ff) begin
         case (mode_ff)
            smcm_pkg::MODE_PASS: begin
               lo_mx = l_raw;
               ro_mx = r_raw;
            end
            smcm_pkg::MODE_MID: begin
               lo_mx = half_sum[SB-1:0];
               ro_mx = half_sum[SB-1:0];
            end
            smcm_pkg::MODE_SIDE: begin
               lo_mx = half_diff[SB-1:0];
               ro_mx = neg_sat(half_diff[SB-1:0]);
            end
            smcm_pkg::MODE_INVERT: begin
               lo_mx = neg_sat(l_raw);
               ro_mx = neg_sat(r_raw);
            end
            smcm_pkg::MODE_SWAP: begin
               lo_mx = r_raw;
               ro_mx = l_raw;
            end
            smcm_pkg::MODE_SIDE_MONO: begin
               lo_mx = half_diff[SB-1:0];
               ro_mx = half_diff[SB-1:0];
            end
            smcm_pkg::MODE_LEFT_MONO: begin
               lo_mx = l_raw;
               ro_mx = l_raw;
            end
            smcm_pkg::MODE_RIGHT_MONO: begin
               lo_mx = r_raw;
               ro_mx = r_raw;
            end
            default: ;
         endcase
      end
      ro_fin = rinv_ff ? neg_sat(ro_mx) : ro_mx;
   end

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smcm_pkg::ST_IDLE:     if (req_tvalid) state_in = smcm_pkg::ST_MUL;
         smcm_pkg::ST_MUL:      if (cnt_ff == '0) state_in = smcm_pkg::ST_ACCUM;
         smcm_pkg::ST_ACCUM:    state_in = last_ff ? smcm_pkg::ST_PREP : smcm_pkg::ST_DONE;
         smcm_pkg::ST_PREP:     state_in = div_skip ? smcm_pkg::ST_SMOOTH_A : smcm_pkg::ST_DIV;
         smcm_pkg::ST_DIV:      if (cnt_ff == '0) state_in = smcm_pkg::ST_SMOOTH_A;
         smcm_pkg::ST_SMOOTH_A: state_in = smcm_pkg::ST_SMOOTH_B;
         smcm_pkg::ST_SMOOTH_B: state_in = smcm_pkg::ST_DONE;
         smcm_pkg::ST_DONE:     if (!rsp_valid_ff || rsp_tready) state_in = smcm_pkg::ST_IDLE;
         default:               state_in = smcm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      mac_ctl.load = 1'b0;
      mac_ctl.step = 1'b0;
      load_out     = 1'b0;
      case (state_ff)
         smcm_pkg::ST_IDLE: begin
            req_tready   = 1'b1;
            mac_ctl.load = req_tvalid;
         end
         smcm_pkg::ST_MUL:  mac_ctl.step = 1'b1;
         smcm_pkg::ST_DONE: load_out = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   assign accept = req_tvalid & req_tready;

   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         cnt_in = MUL_LAST;
      end else if (state_ff == smcm_pkg::ST_PREP) begin
         cnt_in = DIV_LAST;
      end else if ((state_ff == smcm_pkg::ST_MUL || state_ff == smcm_pkg::ST_DIV) &&
                   cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   smcm_mac #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_mac (
      .clock   (clock),
      .ctl     (mac_ctl),
      .mag_l   (mag_of(lo_mx)),
      .mag_r   (mag_of(ro_fin)),
      .prod_lr (prod_lr),
      .prod_ll (prod_ll),
      .prod_rr (prod_rr)
   );

   // ---------------------------------------------------------------- sums
   always_comb begin
      prod_signed = neg_ff ? -$signed(prod_lr) : $signed(prod_lr);
      psum_acc = {{(ACC_W - SUM_W){psum_ff[SUM_W-1]}}, psum_ff} +
                 {{(ACC_W - PROD_W){prod_signed[PROD_W-1]}}, prod_signed};
      sq_new   = {1'b0, prod_ll} + {1'b0, prod_rr};
      ssum_acc = {{(ACC_W - SUM_W){1'b0}}, ssum_ff} + {{(ACC_W - SQ_W){1'b0}}, sq_new};
      psum_in  = psum_ff;
      ssum_in  = ssum_ff;
      if (state_ff == smcm_pkg::ST_ACCUM) begin
         if (psum_acc > PSUM_MAX) begin
            psum_in = PSUM_MAX[SUM_W-1:0];
         end else if (psum_acc < PSUM_MIN) begin
            psum_in = PSUM_MIN[SUM_W-1:0];
         end else begin
            psum_in = psum_acc[SUM_W-1:0];
         end
         ssum_in = (ssum_acc > SSUM_MAX) ? {SUM_W{1'b1}} : ssum_acc[SUM_W-1:0];
      end else if (state_ff == smcm_pkg::ST_SMOOTH_B) begin
         psum_in = '0;
         ssum_in = '0;
      end
   end

   // ---------------------------------------------------------------- divider
   assign mag_p     = psum_ff[SUM_W-1] ? (~psum_ff + 1'b1) : psum_ff;
   assign div_skip  = (ssum_ff <= SILENCE) || (mag_p >= ssum_ff);
   assign rem_shift = {rem_ff[SUM_W-1:0], 1'b0};

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      zero_in = zero_ff;
      case (state_ff)
         smcm_pkg::ST_PREP: begin
            rem_in  = {1'b0, mag_p};
            zero_in = ssum_ff <= SILENCE;
            q_in    = (ssum_ff > SILENCE && mag_p >= ssum_ff) ? Q_FULL : '0;
         end
         smcm_pkg::ST_DIV: begin
            if (rem_shift >= {1'b0, ssum_ff}) begin
               rem_in = rem_shift - {1'b0, ssum_ff};
               q_in   = {q_ff[Q_W-2:0], 1'b1};
            end else begin
               rem_in = rem_shift;
               q_in   = {q_ff[Q_W-2:0], 1'b0};
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- smoothing
   always_comb begin
      if (zero_ff) begin
         fresh = '0;
      end else if (psum_ff[SUM_W-1]) begin
         fresh = (q_ff >= Q_NEG_LIM) ? 16'sh8000 : -$signed(q_ff[15:0]);
      end else begin
         fresh = (q_ff >= Q_POS_LIM) ? 16'sh7fff : $signed(q_ff[15:0]);
      end
      new_part   = fresh_ff * smcm_pkg::NEW_Q15;
      smooth_acc = {keep_ff[31], keep_ff} + {new_part[31], new_part} + smcm_pkg::ROUND_Q15;
      corr_in    = (state_ff == smcm_pkg::ST_SMOOTH_B) ? smooth_acc[30:15] : corr_ff;
   end

   // ---------------------------------------------------------------- output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = OUT_W'({corr_ff, ro_ff, lo_ff});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= smcm_pkg::MODE_PASS;
         bypass_ff    <= 1'b0;
         rinv_ff      <= 1'b0;
         state_ff     <= smcm_pkg::ST_IDLE;
         psum_ff      <= '0;
         ssum_ff      <= '0;
         corr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         bypass_ff    <= bypass_in;
         rinv_ff      <= rinv_in;
         state_ff     <= state_in;
         psum_ff      <= psum_in;
         ssum_ff      <= ssum_in;
         corr_ff      <= corr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      zero_ff     <= zero_in;
      rsp_data_ff <= rsp_data_in;
      if (state_ff == smcm_pkg::ST_SMOOTH_A) begin
         fresh_ff <= fresh;
         keep_ff  <= corr_ff * smcm_pkg::KEEP_Q15;
      end
      if (accept) begin
         lo_ff    <= lo_mx;
         ro_ff    <= ro_fin;
         neg_ff   <= lo_mx[SB-1] ^ ro_fin[SB-1];
         last_ff  <= req_tlast;
      end
   end

endmodule

FILE: rtl/smcm_mac.sv
// Bit-serial multiplier for the correlation sums: forms |L|*|R|, |L|*|L| and |R|*|R|.
// One multiplier bit per cycle while ctl.step is set; depends on smcm_pkg.

module smcm_mac #(
   parameter int SAMPLE_BITS = smcm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                       clock,
   input  smcm_pkg::mac_ctl_type      ctl,
   input  logic [SAMPLE_BITS-1:0]     mag_l,
   input  logic [SAMPLE_BITS-1:0]     mag_r,
   output logic [2*SAMPLE_BITS-1:0]   prod_lr,
   output logic [2*SAMPLE_BITS-1:0]   prod_ll,
   output logic [2*SAMPLE_BITS-1:0]   prod_rr
);

   localparam int SB = SAMPLE_BITS;

   logic [SB-1:0]   mcl_ff, mcl_in, mcr_ff, mcr_in;
   logic [SB-1:0]   shl_ff, shl_in, shr_ff, shr_in;
   logic [2*SB-1:0] acc_lr_ff, acc_lr_in, acc_ll_ff, acc_ll_in, acc_rr_ff, acc_rr_in;
   logic [SB:0]     sum_lr, sum_ll, sum_rr;

   // The upper half takes the partial product and the whole word moves one bit right.
   always_comb begin
      sum_lr = {1'b0, acc_lr_ff[2*SB-1:SB]} + (shr_ff[0] ? {1'b0, mcl_ff} : '0);
      sum_ll = {1'b0, acc_ll_ff[2*SB-1:SB]} + (shl_ff[0] ? {1'b0, mcl_ff} : '0);
      sum_rr = {1'b0, acc_rr_ff[2*SB-1:SB]} + (shr_ff[0] ? {1'b0, mcr_ff} : '0);
      mcl_in    = mcl_ff;
      mcr_in    = mcr_ff;
      shl_in    = shl_ff;
      shr_in    = shr_ff;
      acc_lr_in = acc_lr_ff;
      acc_ll_in = acc_ll_ff;
      acc_rr_in = acc_rr_ff;
      if (ctl.load) begin
         mcl_in    = mag_l;
         mcr_in    = mag_r;
         shl_in    = mag_l;
         shr_in    = mag_r;
         acc_lr_in = '0;
         acc_ll_in = '0;
         acc_rr_in = '0;
      end else if (ctl.step) begin
         shl_in    = {1'b0, shl_ff[SB-1:1]};
         shr_in    = {1'b0, shr_ff[SB-1:1]};
         acc_lr_in = {sum_lr, acc_lr_ff[SB-1:1]};
         acc_ll_in = {sum_ll, acc_ll_ff[SB-1:1]};
         acc_rr_in = {sum_rr, acc_rr_ff[SB-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      mcl_ff    <= mcl_in;
      mcr_ff    <= mcr_in;
      shl_ff    <= shl_in;
      shr_ff    <= shr_in;
      acc_lr_ff <= acc_lr_in;
      acc_ll_ff <= acc_ll_in;
      acc_rr_ff <= acc_rr_in;
   end

   assign prod_lr = acc_lr_ff;
   assign prod_ll = acc_ll_ff;
   assign prod_rr = acc_rr_ff;

endmodule

FILE: rtl/smcm_checker.sv
// Port-level checker for the stereo matrix correlation meter, with its bind statement.
// Depends on smcm_pkg and on the top level's port list.

module smcm_checker #(
   parameter  int SAMPLE_BITS = smcm_pkg::SAMPLE_BITS_DEF,
   localparam int OUT_W = ((2 * SAMPLE_BITS + smcm_pkg::CORR_W + 7) / 8) * 8
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [OUT_W-1:0]                  rsp_tdata
);

   // After reset the output register must be empty.
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid straight after reset");

   // Only one word is in flight: acceptance closes the input until it is finished.
   a_one_in_flight : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted again while a word is in progress");

   // A stalled result holds its payload.
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result word changed while stalled");

   // A busy block cannot reopen its input while the output register is still blocked.
   a_busy_stall : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && !req_tready) |=> !req_tready)
      else $error("input reopened while the finished word could not be stored");

endmodule

bind stereo_matrix_correlation_meter_top smcm_checker #(
   .SAMPLE_BITS(SAMPLE_BITS)
) u_smcm_checker (.*);
